[src/lpd_pkg.sv]
// Shared types and constants for the length-prefixed deframer.
// Used by lpd_core, lpd_out_stage and length_prefix_deframer_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

  localparam logic [2:0]  HEADER_BYTES   = 3'd4;
  localparam logic [31:0] MAX_BODY_RESET = 32'd65536;

  localparam logic [1:0] KIND_BODY  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        packet_last;
    logic [31:0] bad_length;
  } res_t;

endpackage

`default_nettype wire

[src/lpd_core.sv]
// Framing state and per-beat decode: header collection, length check, body count.
// Depends on lpd_pkg for the result type and the kind codes.
`timescale 1ns / 1ps
`default_nettype none

module lpd_core import lpd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [31:0] cfg_data,
  input  wire logic        take,
  input  wire logic [7:0]  in_byte,
  input  wire logic        chunk_end,
  output logic             res_valid,
  output res_t             res
);

  logic [2:0]  header_count, header_count_next;
  logic [31:0] length_shift, length_shift_next;
  logic [31:0] body_left, body_left_next;
  logic        discarding, discarding_next;
  logic [31:0] max_body_len;

  logic        hdr_done;
  logic        in_body;
  logic [2:0]  eff_count;
  logic [31:0] eff_shift;
  logic [2:0]  new_count;
  logic [31:0] new_shift;

  assign hdr_done  = (header_count >= HEADER_BYTES);
  assign in_body   = hdr_done && (body_left != 32'd0);
  assign eff_count = (hdr_done && !in_body) ? 3'd0 : header_count;
  assign eff_shift = (hdr_done && !in_body) ? 32'd0 : length_shift;
  assign new_count = eff_count + 3'd1;
  assign new_shift = {eff_shift[23:0], in_byte};

  always_comb begin
    header_count_next = header_count;
    length_shift_next = length_shift;
    body_left_next    = body_left;
    discarding_next   = discarding;
    res_valid         = 1'b0;
    res               = '0;
    if (discarding) begin
      if (chunk_end) begin
        discarding_next = 1'b0;
      end
    end else if (in_body) begin
      res_valid       = 1'b1;
      res.kind        = KIND_BODY;
      res.out_byte    = in_byte;
      if (body_left == 32'd1) begin
        res.packet_last   = 1'b1;
        header_count_next = 3'd0;
        length_shift_next = 32'd0;
        body_left_next    = 32'd0;
      end else begin
        body_left_next = body_left - 32'd1;
      end
    end else if (new_count < HEADER_BYTES) begin
      header_count_next = new_count;
      length_shift_next = new_shift;
      body_left_next    = 32'd0;
    end else if (new_shift > max_body_len) begin
      header_count_next = 3'd0;
      length_shift_next = 32'd0;
      body_left_next    = 32'd0;
      discarding_next   = !chunk_end;
      res_valid         = 1'b1;
      res.kind          = KIND_ERROR;
      res.packet_last   = 1'b1;
      res.bad_length    = new_shift;
    end else if (new_shift == 32'd0) begin
      header_count_next = 3'd0;
      length_shift_next = 32'd0;
      body_left_next    = 32'd0;
      res_valid         = 1'b1;
      res.kind          = KIND_EMPTY;
      res.packet_last   = 1'b1;
    end else begin
      header_count_next = new_count;
      length_shift_next = new_shift;
      body_left_next    = new_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= 3'd0;
      length_shift <= 32'd0;
      body_left    <= 32'd0;
      discarding   <= 1'b0;
      max_body_len <= MAX_BODY_RESET;
    end else begin
      if (take) begin
        header_count <= header_count_next;
        length_shift <= length_shift_next;
        body_left    <= body_left_next;
        discarding   <= discarding_next;
      end
      if (cfg_write) begin
        max_body_len <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

[src/lpd_out_stage.sv]
// Result register with valid/stall handshake toward the downstream side.
// Depends on lpd_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module lpd_out_stage import lpd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire logic load_valid,
  input  res_t      load_res,
  input  wire logic out_stall,
  output logic      out_valid,
  output res_t      out_res,
  output logic      full_blocked
);

  assign full_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      out_res <= load_res;
    end
  end

endmodule

`default_nettype wire

[src/length_prefix_deframer_unit.sv]
// Top level of the length-prefixed byte stream deframer.
// Depends on lpd_pkg, lpd_core and lpd_out_stage.
//
// Each input beat is one stream byte; it is decoded combinationally and its result, if
// any, lands in a single output register, so one beat is accepted every cycle while
// that register is empty or being taken. A beat's result is on the output in the cycle
// after the beat is taken. Input stall rises only while a held result is stalled
// downstream. The length limit is written through cfg_write/cfg_data and resets to 65536.
`timescale 1ns / 1ps
`default_nettype none

module length_prefix_deframer_unit import lpd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        chunk_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       out_byte,
  output logic             packet_last,
  output logic [31:0]      bad_length
);

  logic take;
  logic res_valid;
  res_t res;
  res_t out_res;
  logic full_blocked;

  assign in_stall = full_blocked;
  assign take     = in_valid && !full_blocked;

  lpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .take      (take),
    .in_byte   (in_byte),
    .chunk_end (chunk_end),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (take),
    .load_valid   (res_valid),
    .load_res     (res),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_res      (out_res),
    .full_blocked (full_blocked)
  );

  assign kind        = out_res.kind;
  assign out_byte    = out_res.out_byte;
  assign packet_last = out_res.packet_last;
  assign bad_length  = out_res.bad_length;

endmodule

`default_nettype wire
